>>> hw/rtl/sitc_pkg.sv
// Package for the spiral index to coordinate block: step codes, control word and microcode ROM.
package sitc_pkg;

  // Field widths
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned LEFT_W = 18;
  localparam int unsigned PC_W   = 4;

  // Program steps
  localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
  localparam logic [PC_W-1:0] ST_MRC  = 4'd1;
  localparam logic [PC_W-1:0] ST_CHK  = 4'd2;
  localparam logic [PC_W-1:0] ST_TEST = 4'd3;
  localparam logic [PC_W-1:0] ST_MMID = 4'd4;
  localparam logic [PC_W-1:0] ST_CMP  = 4'd5;
  localparam logic [PC_W-1:0] ST_MK   = 4'd6;
  localparam logic [PC_W-1:0] ST_LEFT = 4'd7;
  localparam logic [PC_W-1:0] ST_EMIT = 4'd8;

  // Wait conditions: hold the step until the channel is ready
  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_IN   = 2'd1;
  localparam logic [1:0] W_OUT  = 2'd2;

  // Multiplier operand selects: (rows - 2x) * (cols - 2x)
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_RC   = 2'd1;
  localparam logic [1:0] MUL_MID  = 2'd2;
  localparam logic [1:0] MUL_K    = 2'd3;

  // Datapath operations
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_CHECK  = 3'd2;
  localparam logic [2:0] OP_MID    = 3'd3;
  localparam logic [2:0] OP_UPDATE = 3'd4;
  localparam logic [2:0] OP_LEFT   = 3'd5;
  localparam logic [2:0] OP_EMIT   = 3'd6;

  // Jump conditions: taken goes to target, otherwise to the next step
  localparam logic [1:0] C_NEXT     = 2'd0;
  localparam logic [1:0] C_ALWAYS   = 2'd1;
  localparam logic [1:0] C_OOR      = 2'd2;
  localparam logic [1:0] C_LO_GT_HI = 2'd3;

  typedef struct packed {
    logic [1:0]      wait_on;
    logic [1:0]      mul_sel;
    logic [2:0]      op;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    case (pc)
      ST_IDLE: uw = '{W_IN,   MUL_NONE, OP_LOAD,   C_NEXT,     ST_IDLE};
      ST_MRC:  uw = '{W_NONE, MUL_RC,   OP_NOP,    C_NEXT,     ST_IDLE};
      ST_CHK:  uw = '{W_NONE, MUL_NONE, OP_CHECK,  C_OOR,      ST_EMIT};
      ST_TEST: uw = '{W_NONE, MUL_NONE, OP_MID,    C_LO_GT_HI, ST_MK};
      ST_MMID: uw = '{W_NONE, MUL_MID,  OP_NOP,    C_NEXT,     ST_IDLE};
      ST_CMP:  uw = '{W_NONE, MUL_NONE, OP_UPDATE, C_ALWAYS,   ST_TEST};
      ST_MK:   uw = '{W_NONE, MUL_K,    OP_NOP,    C_NEXT,     ST_IDLE};
      ST_LEFT: uw = '{W_NONE, MUL_NONE, OP_LEFT,   C_NEXT,     ST_IDLE};
      ST_EMIT: uw = '{W_OUT,  MUL_NONE, OP_EMIT,   C_ALWAYS,   ST_IDLE};
      default: uw = '{W_NONE, MUL_NONE, OP_NOP,    C_ALWAYS,   ST_IDLE};
    endcase
    return uw;
  endfunction

endpackage

>>> hw/rtl/spiral_index_to_coordinate.sv
// Top level of the spiral index to coordinate block: microcoded search and output register.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata: rows, cols, position
//  out_    | out | out_tvalid/out_tready | tdata: row, column; tuser: out_of_range
//
// An item is handled by a binary search over ring numbers, each iteration taking a
// midpoint, a multiply and a compare step; an out-of-range position goes from the
// check step straight to the emit step. A single 16x16 multiplier is shared by the
// rows*cols, midpoint and final-ring multiplies. A new item is taken only at the idle step.
// Synchronous active-low reset returns the sequencer to its idle step and empties the
// output register. A waiting result does not block: the sequencer stalls only at its
// final step when the output register is still full.
module spiral_index_to_coordinate
  import sitc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // rows[15:0], cols[31:16], position[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // row[15:0], column[31:16]
  output logic        out_tuser   // out_of_range[0]
);

  // Sequencer and datapath registers
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  prod_r, rc_r;
  logic [DIM_W-1:0]  lo_r, hi_r, mid_r, k_r;
  logic              oor_r;
  logic [LEFT_W-1:0] left_r;
  logic [DIM_W-1:0]  h_r, w_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;
  logic              out_user_r;

  ucode_t            uw;
  logic              stall;
  logic              taken;
  logic              oor_now;
  logic              lo_gt_hi;
  logic [DIM_W-1:0]  mul_x, mul_a, mul_b;
  logic [DIM_W-1:0]  tmin;
  logic [POS_W-1:0]  cb;
  logic              out_busy;

  // Side selection signals
  logic [LEFT_W-1:0] kx, hx, wx, rx, cx;
  logic [LEFT_W-1:0] lim_right, lim_bottom;
  logic [LEFT_W-1:0] row_calc, col_calc;

  // Decode the current control word
  assign uw       = ucode_rom(pc_r);
  assign out_busy = out_valid_r && !out_tready;
  assign in_tready = (pc_r == ST_IDLE);

  always_comb begin
    case (uw.wait_on)
      W_IN:    stall = !in_tvalid;
      W_OUT:   stall = out_busy;
      default: stall = 1'b0;
    endcase
  end

  // Range check against rows*cols held in the product register
  assign oor_now  = (pos_r == '0) || (rows_r == '0) || (cols_r == '0) || (pos_r > prod_r);
  assign lo_gt_hi = (lo_r > hi_r);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_OOR:      taken = oor_now;
      C_LO_GT_HI: taken = lo_gt_hi;
      default:    taken = 1'b0;
    endcase
  end

  // Advance the step counter, or jump, or hold on a wait
  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Multiplier operands: sub-grid inside ring x
  always_comb begin
    case (uw.mul_sel)
      MUL_MID: mul_x = mid_r;
      MUL_K:   mul_x = k_r;
      default: mul_x = '0;
    endcase
  end

  assign mul_a = rows_r - {mul_x[DIM_W-2:0], 1'b0};
  assign mul_b = cols_r - {mul_x[DIM_W-2:0], 1'b0};
  assign tmin  = (rows_r < cols_r) ? rows_r : cols_r;
  assign cb    = rc_r - prod_r;

  always_ff @(posedge clk) begin
    if (uw.mul_sel != MUL_NONE) begin
      prod_r <= POS_W'(mul_a) * POS_W'(mul_b);
    end
  end

  // Datapath operations
  always_ff @(posedge clk) begin
    if (!stall) begin
      case (uw.op)
        OP_LOAD: begin
          rows_r <= in_tdata[15:0];
          cols_r <= in_tdata[31:16];
          pos_r  <= in_tdata[63:32];
        end
        OP_CHECK: begin
          rc_r  <= prod_r;
          oor_r <= oor_now;
          lo_r  <= '0;
          hi_r  <= (tmin - 1'b1) >> 1;
          k_r   <= '0;
        end
        OP_MID: begin
          mid_r <= lo_r + ((hi_r - lo_r) >> 1);
        end
        OP_UPDATE: begin
          if (cb < pos_r) begin
            k_r  <= mid_r;
            lo_r <= mid_r + 1'b1;
          end else begin
            hi_r <= mid_r - 1'b1;
          end
        end
        OP_LEFT: begin
          left_r <= LEFT_W'(pos_r - cb);
          h_r    <= rows_r - {k_r[DIM_W-2:0], 1'b0};
          w_r    <= cols_r - {k_r[DIM_W-2:0], 1'b0};
        end
        default: begin
        end
      endcase
    end
  end

  // Pick the side of the ring and form the coordinate
  assign kx = {2'b00, k_r};
  assign hx = {2'b00, h_r};
  assign wx = {2'b00, w_r};
  assign rx = {2'b00, rows_r};
  assign cx = {2'b00, cols_r};
  assign lim_right  = wx + hx - 1'b1;
  assign lim_bottom = {wx[LEFT_W-2:0], 1'b0} + hx - 2'd2;

  always_comb begin
    if (h_r == 16'd1) begin
      row_calc = kx + 1'b1;
      col_calc = kx + left_r;
    end else if (w_r == 16'd1) begin
      row_calc = kx + left_r;
      col_calc = kx + 1'b1;
    end else if (left_r <= wx) begin
      row_calc = kx + 1'b1;
      col_calc = kx + left_r;
    end else if (left_r <= lim_right) begin
      row_calc = kx + 1'b1 + (left_r - wx);
      col_calc = cx - kx;
    end else if (left_r <= lim_bottom) begin
      row_calc = rx - kx;
      col_calc = cx - kx - (left_r - lim_right);
    end else begin
      row_calc = rx - kx - (left_r - lim_bottom);
      col_calc = kx + 1'b1;
    end
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((uw.op == OP_EMIT) && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.op == OP_EMIT) && !stall) begin
      out_user_r <= oor_r;
      if (oor_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {col_calc[DIM_W-1:0], row_calc[DIM_W-1:0]};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  // An accepted item starts the program at the rows*cols multiply
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (pc_r == ST_MRC))
    else $error("sequencer did not start after input transfer");

  // The step counter stays inside the program
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r <= ST_EMIT))
    else $error("step counter outside program");

  // Search bounds never cross by more than one
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_TEST) |-> ({1'b0, lo_r} <= {1'b0, hi_r} + 17'd1))
    else $error("search bounds crossed");

  // An in-range result carries a 1-based coordinate
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r) |-> ((out_data_r[15:0] != '0) && (out_data_r[31:16] != '0)))
    else $error("in-range result with zero coordinate");

  // A result emitted while the output register is busy would be lost
  assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == ST_EMIT) && out_valid_r && !out_tready) |=> (pc_r == ST_EMIT))
    else $error("result emitted over a waiting result");
`endif

endmodule
